// ===== rtl/hpt_pkg.sv =====
`default_nettype none

package hpt_pkg;

    // Characters that steer the parse
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    // Result event queue geometry
    localparam int EVQ_DEPTH = 4;
    localparam int EVQ_AW    = $clog2(EVQ_DEPTH);

    typedef enum logic [2:0] {
        PH_NAME_WS  = 3'd0,
        PH_NAME     = 3'd1,
        PH_VAL_WS   = 3'd2,
        PH_VAL      = 3'd3,
        PH_QUOTE_WS = 3'd4,
        PH_QUOTE    = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        KIND_NAME_BYTE = 3'd0,
        KIND_VAL_BYTE  = 3'd1,
        KIND_DISCARD   = 3'd2,
        KIND_TAG_VAL   = 3'd3,
        KIND_TAG_NAME  = 3'd4,
        KIND_DROPPED   = 3'd5
    } kind_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
    } out_beat_t;

    // Events produced by one input character (cnt is 0, 1 or 2)
    typedef struct packed {
        logic [1:0] cnt;
        out_beat_t  ev0;
        out_beat_t  ev1;
    } ev_set_t;

endpackage

`default_nettype wire

// ===== rtl/hpt_step.sv =====
`default_nettype none

module hpt_step (
    input  wire hpt_pkg::phase_t   phase,
    input  wire hpt_pkg::in_beat_t beat,
    output hpt_pkg::phase_t        phase_next,
    output hpt_pkg::ev_set_t       events
);

    logic               p_valid;
    hpt_pkg::out_beat_t p_beat;
    hpt_pkg::phase_t    p_phase;
    logic               l_valid;
    hpt_pkg::kind_t     l_kind;
    logic [7:0]         c;

    assign c = beat.byte_in;

    // Advance the phase on one character
    always_comb begin
        p_valid          = 1'b0;
        p_beat.kind      = hpt_pkg::KIND_NAME_BYTE;
        p_beat.data_byte = 8'h00;
        p_phase          = phase;
        case (phase)
            hpt_pkg::PH_NAME: begin
                if (c == hpt_pkg::CH_EQUAL) begin
                    p_phase = hpt_pkg::PH_VAL_WS;
                end else if (c == hpt_pkg::CH_SEMI) begin
                    p_valid     = 1'b1;
                    p_beat.kind = hpt_pkg::KIND_TAG_NAME;
                    p_phase     = hpt_pkg::PH_NAME_WS;
                end else begin
                    p_valid          = 1'b1;
                    p_beat.kind      = hpt_pkg::KIND_NAME_BYTE;
                    p_beat.data_byte = c;
                end
            end
            hpt_pkg::PH_VAL_WS: begin
                if (c == hpt_pkg::CH_SPACE) begin
                    p_phase = hpt_pkg::PH_VAL_WS;
                end else if (c == hpt_pkg::CH_SEMI) begin
                    p_valid     = 1'b1;
                    p_beat.kind = hpt_pkg::KIND_DROPPED;
                    p_phase     = hpt_pkg::PH_NAME_WS;
                end else if (c == hpt_pkg::CH_QUOTE) begin
                    p_phase = hpt_pkg::PH_QUOTE_WS;
                end else begin
                    p_valid          = 1'b1;
                    p_beat.kind      = hpt_pkg::KIND_VAL_BYTE;
                    p_beat.data_byte = c;
                    p_phase          = hpt_pkg::PH_VAL;
                end
            end
            hpt_pkg::PH_VAL: begin
                if (c == hpt_pkg::CH_SEMI) begin
                    p_valid     = 1'b1;
                    p_beat.kind = hpt_pkg::KIND_TAG_VAL;
                    p_phase     = hpt_pkg::PH_NAME_WS;
                end else if (c == hpt_pkg::CH_QUOTE) begin
                    p_valid     = 1'b1;
                    p_beat.kind = hpt_pkg::KIND_DISCARD;
                    p_phase     = hpt_pkg::PH_QUOTE_WS;
                end else begin
                    p_valid          = 1'b1;
                    p_beat.kind      = hpt_pkg::KIND_VAL_BYTE;
                    p_beat.data_byte = c;
                end
            end
            hpt_pkg::PH_QUOTE_WS: begin
                if (c == hpt_pkg::CH_SPACE) begin
                    p_phase = hpt_pkg::PH_QUOTE_WS;
                end else if (c == hpt_pkg::CH_QUOTE) begin
                    p_valid     = 1'b1;
                    p_beat.kind = hpt_pkg::KIND_DROPPED;
                    p_phase     = hpt_pkg::PH_NAME_WS;
                end else begin
                    p_valid          = 1'b1;
                    p_beat.kind      = hpt_pkg::KIND_VAL_BYTE;
                    p_beat.data_byte = c;
                    p_phase          = hpt_pkg::PH_QUOTE;
                end
            end
            hpt_pkg::PH_QUOTE: begin
                if (c == hpt_pkg::CH_QUOTE) begin
                    p_valid     = 1'b1;
                    p_beat.kind = hpt_pkg::KIND_TAG_VAL;
                    p_phase     = hpt_pkg::PH_NAME_WS;
                end else begin
                    p_valid          = 1'b1;
                    p_beat.kind      = hpt_pkg::KIND_VAL_BYTE;
                    p_beat.data_byte = c;
                end
            end
            default: begin
                // Skipping spaces before a name; unused codes behave the same
                if (c == hpt_pkg::CH_SPACE || c == hpt_pkg::CH_EQUAL
                        || c == hpt_pkg::CH_SEMI) begin
                    p_phase = hpt_pkg::PH_NAME_WS;
                end else begin
                    p_valid          = 1'b1;
                    p_beat.kind      = hpt_pkg::KIND_NAME_BYTE;
                    p_beat.data_byte = c;
                    p_phase          = hpt_pkg::PH_NAME;
                end
            end
        endcase
    end

    // Close the pending pair on the final character
    always_comb begin
        l_valid = 1'b0;
        l_kind  = hpt_pkg::KIND_DROPPED;
        if (beat.last_byte) begin
            case (p_phase)
                hpt_pkg::PH_NAME: begin
                    l_valid = 1'b1;
                    l_kind  = hpt_pkg::KIND_TAG_NAME;
                end
                hpt_pkg::PH_VAL, hpt_pkg::PH_QUOTE: begin
                    l_valid = 1'b1;
                    l_kind  = hpt_pkg::KIND_TAG_VAL;
                end
                hpt_pkg::PH_VAL_WS, hpt_pkg::PH_QUOTE_WS: begin
                    l_valid = 1'b1;
                    l_kind  = hpt_pkg::KIND_DROPPED;
                end
                default: begin
                    l_valid = 1'b0;
                end
            endcase
        end
        phase_next = beat.last_byte ? hpt_pkg::PH_NAME_WS : p_phase;
    end

    // Pack events in order: character event first, then closing tag
    always_comb begin
        events.ev1.kind      = l_kind;
        events.ev1.data_byte = 8'h00;
        if (p_valid) begin
            events.ev0 = p_beat;
            events.cnt = l_valid ? 2'd2 : 2'd1;
        end else begin
            events.ev0.kind      = l_kind;
            events.ev0.data_byte = 8'h00;
            events.cnt           = l_valid ? 2'd1 : 2'd0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hpt_evq.sv =====
`default_nettype none

module hpt_evq (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      wr_en,
    input  wire hpt_pkg::ev_set_t    wr_events,
    output logic                     room,
    output logic                     m_valid,
    input  wire                      m_ready,
    output hpt_pkg::out_beat_t       m_payload
);

    hpt_pkg::out_beat_t           mem_reg [hpt_pkg::EVQ_DEPTH];
    logic [hpt_pkg::EVQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [hpt_pkg::EVQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [hpt_pkg::EVQ_AW:0]     count_reg, count_next;
    logic [hpt_pkg::EVQ_AW-1:0]   wr_ptr_1;
    logic [hpt_pkg::EVQ_AW:0]     push_n;
    logic                         pop;

    assign pop       = m_valid && m_ready;
    assign push_n    = wr_en ? (hpt_pkg::EVQ_AW+1)'(wr_events.cnt) : '0;
    assign wr_ptr_1  = wr_ptr_reg + 1'b1;
    assign m_valid   = (count_reg != '0);
    assign m_payload = mem_reg[rd_ptr_reg];
    // Room for a full pair of events, independent of the downstream side
    assign room      = (count_reg <= (hpt_pkg::EVQ_AW+1)'(hpt_pkg::EVQ_DEPTH - 2));

    // Advance pointers and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg + hpt_pkg::EVQ_AW'(push_n);
        rd_ptr_next = rd_ptr_reg + hpt_pkg::EVQ_AW'(pop);
        count_next  = count_reg + push_n - (hpt_pkg::EVQ_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store up to two event beats per cycle
    always_ff @(posedge aclk) begin
        if (wr_en && wr_events.cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= wr_events.ev0;
        end
        if (wr_en && wr_events.cnt == 2'd2) begin
            mem_reg[wr_ptr_1] <= wr_events.ev1;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (hpt_pkg::EVQ_AW+1)'(hpt_pkg::EVQ_DEPTH))
        else $error("event queue overfilled");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && wr_events.cnt != 2'd0) |-> room)
        else $error("event written without room");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        hpt_pkg::EVQ_AW'(count_reg) == hpt_pkg::EVQ_AW'(wr_ptr_reg - rd_ptr_reg))
        else $error("event queue pointers disagree with fill level");

endmodule

`default_nettype wire

// ===== rtl/header_param_tokenizer.sv =====
// A character beat is held in the input stage register, then its events are written
// into the event queue; a second event from the same character follows the first.
// Throughput: one character per cycle while each character produces at most one event
// and m_ready holds; the port drains one event per cycle via a four-entry event queue.
// Reset (aresetn low, synchronous): parse phase returns to skipping spaces before a
// name, the input stage and event queue empty; no event beats are pending.
`default_nettype none

module header_param_tokenizer (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      s_valid,
    output logic                     s_ready,
    input  wire hpt_pkg::in_beat_t   s_payload,
    output logic                     m_valid,
    input  wire                      m_ready,
    output hpt_pkg::out_beat_t       m_payload
);

    logic              in_valid_reg, in_valid_next;
    hpt_pkg::in_beat_t in_beat_reg;
    hpt_pkg::phase_t   phase_reg, phase_next;
    hpt_pkg::phase_t   step_phase;
    hpt_pkg::ev_set_t  step_events;
    logic              room;
    logic              advance;
    logic              s_fire;

    // Consume the held beat whenever the queue can take two events
    assign advance = in_valid_reg && room;
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    hpt_step u_step (
        .phase      (phase_reg),
        .beat       (in_beat_reg),
        .phase_next (step_phase),
        .events     (step_events)
    );

    hpt_evq u_evq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (advance),
        .wr_events (step_events),
        .room      (room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // Input stage and phase update
    always_comb begin
        in_valid_next = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        phase_next    = advance ? step_phase : phase_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            phase_reg    <= hpt_pkg::PH_NAME_WS;
        end else begin
            in_valid_reg <= in_valid_next;
            phase_reg    <= phase_next;
        end
    end

    // Hold the payload until it is consumed
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_beat_reg <= s_payload;
        end
    end

    a_last_resets_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_beat_reg.last_byte) |=> (phase_reg == hpt_pkg::PH_NAME_WS))
        else $error("phase not restored after final character");

    a_phase_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(phase_reg))
        else $error("phase changed without a consumed beat");

    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input stage empty but not ready");

endmodule

`default_nettype wire
